/* design/fusd_pkg.sv */
// fusd_pkg: types and constants of the framed UTF-8 symbol decoder.
// No dependencies; used by the interfaces, fusd_step and the top level.
package fusd_pkg;

    localparam logic [7:0] BYTE_SOT   = 8'h81;
    localparam logic [7:0] BYTE_EOT   = 8'h82;
    localparam logic [7:0] BYTE_SOB   = 8'h83;
    localparam logic [7:0] BYTE_EOB   = 8'h84;
    localparam logic [7:0] BYTE_DELIM = 8'h85;

    localparam int unsigned VALUE_W = 21;

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_OUT   = 5'b00010,
        PH_IN    = 5'b00100,
        PH_CONT  = 5'b01000,
        PH_ERR   = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SYMBOL    = 2'd0,
        KIND_BLOCK_END = 2'd1,
        KIND_END       = 2'd2,
        KIND_ERROR     = 2'd3
    } t_kind;

    typedef struct packed {
        t_phase               phase;
        logic [1:0]           pend;
        logic [VALUE_W-1:0]   partial;
        logic                 rule_start;
    } t_state;

    typedef struct packed {
        logic                 valid;
        t_kind                kind;
        logic [VALUE_W-1:0]   value;
        logic                 starts_rule;
    } t_result;

endpackage

/* design/fusd_if.sv */
// fusd_if: valid/ready channel interfaces for the byte input and the result output.
// Depends on fusd_pkg for the result kind type.
interface fusd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface fusd_sym_if;
    logic                             valid;
    logic                             ready;
    fusd_pkg::t_kind                  kind;
    logic [fusd_pkg::VALUE_W-1:0]     symbol_value;
    logic                             starts_rule;

    modport source (output valid, output kind, output symbol_value, output starts_rule,
                    input ready);
    modport sink (input valid, input kind, input symbol_value, input starts_rule,
                  output ready);
endinterface

/* design/fusd_step.sv */
// fusd_step: combinational next-state and result logic for one input byte.
// Depends on fusd_pkg.
module fusd_step (
    input  fusd_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    output fusd_pkg::t_state  o_state,
    output fusd_pkg::t_result o_result
);

    logic [fusd_pkg::VALUE_W-1:0] w_shifted;
    logic [1:0]                   w_pend_dec;

    assign w_shifted  = {i_state.partial[fusd_pkg::VALUE_W-7:0], i_byte[5:0]};
    assign w_pend_dec = i_state.pend - 2'd1;

    always_comb begin
        o_state  = i_state;
        o_result = '{valid: 1'b0, kind: fusd_pkg::KIND_SYMBOL, value: '0,
                     starts_rule: 1'b0};

        unique case (i_state.phase) inside
            fusd_pkg::PH_START: begin
                if (i_byte == fusd_pkg::BYTE_SOT) begin
                    o_state.phase = fusd_pkg::PH_OUT;
                end else begin
                    o_state.phase   = fusd_pkg::PH_ERR;
                    o_state.pend    = '0;
                    o_state.partial = '0;
                    o_result.valid  = 1'b1;
                    o_result.kind   = fusd_pkg::KIND_ERROR;
                end
            end
            fusd_pkg::PH_OUT, fusd_pkg::PH_IN: begin
                if (i_byte == fusd_pkg::BYTE_EOT) begin
                    o_state.phase      = fusd_pkg::PH_START;
                    o_state.pend       = '0;
                    o_state.partial    = '0;
                    o_state.rule_start = 1'b1;
                    o_result.valid     = 1'b1;
                    o_result.kind      = fusd_pkg::KIND_END;
                end else if (i_byte == fusd_pkg::BYTE_EOB) begin
                    o_state.phase      = fusd_pkg::PH_OUT;
                    o_state.rule_start = 1'b1;
                    o_result.valid     = 1'b1;
                    o_result.kind      = fusd_pkg::KIND_BLOCK_END;
                end else if (i_byte == fusd_pkg::BYTE_DELIM) begin
                    o_state.rule_start = 1'b1;
                end else if (i_state.phase == fusd_pkg::PH_OUT) begin
                    if (i_byte == fusd_pkg::BYTE_SOB) begin
                        o_state.phase = fusd_pkg::PH_IN;
                    end
                end else if (i_byte[7:3] == 5'b11110) begin
                    o_state.partial = {{(fusd_pkg::VALUE_W-3){1'b0}}, i_byte[2:0]};
                    o_state.pend    = 2'd3;
                    o_state.phase   = fusd_pkg::PH_CONT;
                end else if (i_byte[7:4] == 4'b1110) begin
                    o_state.partial = {{(fusd_pkg::VALUE_W-4){1'b0}}, i_byte[3:0]};
                    o_state.pend    = 2'd2;
                    o_state.phase   = fusd_pkg::PH_CONT;
                end else if (i_byte[7:5] == 3'b110) begin
                    o_state.partial = {{(fusd_pkg::VALUE_W-5){1'b0}}, i_byte[4:0]};
                    o_state.pend    = 2'd1;
                    o_state.phase   = fusd_pkg::PH_CONT;
                end else if (!i_byte[7]) begin
                    o_state.phase        = fusd_pkg::PH_IN;
                    o_state.pend         = '0;
                    o_state.partial      = '0;
                    o_state.rule_start   = 1'b0;
                    o_result.valid       = 1'b1;
                    o_result.kind        = fusd_pkg::KIND_SYMBOL;
                    o_result.value       = {{(fusd_pkg::VALUE_W-7){1'b0}}, i_byte[6:0]};
                    o_result.starts_rule = i_state.rule_start;
                end else begin
                    o_state.phase   = fusd_pkg::PH_ERR;
                    o_state.pend    = '0;
                    o_state.partial = '0;
                    o_result.valid  = 1'b1;
                    o_result.kind   = fusd_pkg::KIND_ERROR;
                end
            end
            fusd_pkg::PH_CONT: begin
                if (i_byte[7:6] != 2'b10) begin
                    o_state.phase   = fusd_pkg::PH_ERR;
                    o_state.pend    = '0;
                    o_state.partial = '0;
                    o_result.valid  = 1'b1;
                    o_result.kind   = fusd_pkg::KIND_ERROR;
                end else if (w_pend_dec == 2'd0) begin
                    o_state.phase        = fusd_pkg::PH_IN;
                    o_state.pend         = '0;
                    o_state.partial      = '0;
                    o_state.rule_start   = 1'b0;
                    o_result.valid       = 1'b1;
                    o_result.kind        = fusd_pkg::KIND_SYMBOL;
                    o_result.value       = w_shifted;
                    o_result.starts_rule = i_state.rule_start;
                end else begin
                    o_state.partial = w_shifted;
                    o_state.pend    = w_pend_dec;
                end
            end
            default: begin
                // error phase: sticky until reset
            end
        endcase
    end

endmodule

/* design/framed_utf8_symbol_decoder.sv */
// framed_utf8_symbol_decoder: top level, byte input register, state, result register.
// Depends on fusd_pkg, fusd_if (fusd_byte_if, fusd_sym_if) and fusd_step.
//
//  channel   dir  payload                             request when
//  i_byte    in   data_byte[7:0]                      valid && ready
//  o_sym     out  kind[1:0] symbol_value[20:0]        valid && ready
//                 starts_rule
//
// One byte per cycle sustained while o_sym is not stalled. A byte lands in the
// input register, then the decode step updates the state and loads the result
// register when the byte yields a result and the result register is free.
// Synchronous active-low reset: start-of-transmission expected, rule start set.
// A stalled result holds the decode step; a held byte then blocks i_byte.
module framed_utf8_symbol_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fusd_byte_if.sink          i_byte,
    fusd_sym_if.source         o_sym
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    fusd_pkg::t_state  r_state;
    fusd_pkg::t_state  n_state;
    fusd_pkg::t_result n_result;
    logic              r_out_valid;
    fusd_pkg::t_kind   r_out_kind;
    logic [fusd_pkg::VALUE_W-1:0] r_out_value;
    logic              r_out_rs;
    logic              w_out_free;
    logic              w_proc;

    assign w_out_free   = !r_out_valid || o_sym.ready;
    assign w_proc       = r_in_valid && w_out_free;
    assign i_byte.ready = !r_in_valid || w_proc;

    fusd_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: fusd_pkg::PH_START, pend: '0, partial: '0, rule_start: 1'b1};
        end else if (w_proc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && n_result.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_sym.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && n_result.valid) begin
            r_out_kind  <= n_result.kind;
            r_out_value <= n_result.value;
            r_out_rs    <= n_result.starts_rule;
        end
    end

    assign o_sym.valid        = r_out_valid;
    assign o_sym.kind         = r_out_kind;
    assign o_sym.symbol_value = r_out_value;
    assign o_sym.starts_rule  = r_out_rs;

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == fusd_pkg::PH_ERR |-> !n_result.valid)
        else $error("result produced in error phase");

    a_err_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && n_result.valid && n_result.kind == fusd_pkg::KIND_ERROR
        |=> r_state.phase == fusd_pkg::PH_ERR)
        else $error("error result without entering error phase");

    a_pend_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == fusd_pkg::PH_CONT) == (r_state.pend != 2'd0))
        else $error("pending continuation count out of step with phase");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_proc |=> r_in_valid && $stable(r_in_byte))
        else $error("held input byte lost");

endmodule
